// ===== rtl/core/keyword_int_ident_lexer_assert.svh =====
// Assertion macros for the lexer RTL files, used by kil_queue.
// Needs nothing else; a file that asserts includes this header by name.
`ifndef KEYWORD_INT_IDENT_LEXER_ASSERT_SVH
`define KEYWORD_INT_IDENT_LEXER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KIL_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("lexer assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define KIL_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("lexer assertion failed");

`endif

// ===== rtl/core/kil_pkg.sv =====
// Types and constants shared by the lexer front, token queue and back end.
// Depends on nothing.
`default_nettype none

package kil_pkg;

    typedef enum logic [3:0] {
        TOK_END    = 4'd0,
        TOK_FUNC   = 4'd1,
        TOK_EXT    = 4'd2,
        TOK_RET    = 4'd3,
        TOK_IF     = 4'd4,
        TOK_ELSE   = 4'd5,
        TOK_FOR    = 4'd6,
        TOK_INT    = 4'd7,
        TOK_IDENT  = 4'd8,
        TOK_SYMBOL = 4'd9
    } token_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_WORD    = 2'd1,
        MODE_COMMENT = 2'd2
    } scan_mode_t;

    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    localparam logic [62:0] INT_MAX = {63{1'b1}};

    localparam int KW_COUNT = 6;
    // Keyword spellings, first character in the low byte.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_0000_006E_7566,
        64'h0000_6E72_6574_7865,
        64'h0000_0000_0074_6572,
        64'h0000_0000_0000_6669,
        64'h0000_0000_6573_6C65,
        64'h0000_0000_0072_6F66
    };
    localparam logic [7:0] KW_LEN [KW_COUNT] = '{8'd3, 8'd6, 8'd3, 8'd2, 8'd4, 8'd3};
    localparam token_kind_t KW_KIND [KW_COUNT] = '{
        TOK_FUNC, TOK_EXT, TOK_RET, TOK_IF, TOK_ELSE, TOK_FOR
    };

    // A word token. The value holds the INT value or the IDENT text.
    typedef struct packed {
        token_kind_t kind;
        logic [63:0] value;
        logic [7:0]  len;
        logic        ovf;
    } word_tok_t;

    // Everything one character can cause: a word token, then END or a SYMBOL.
    typedef struct packed {
        logic        has_word;
        word_tok_t   word;
        logic        has_sec;
        token_kind_t sec_kind;
        logic [7:0]  sec_sym;
    } tok_pair_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

// ===== rtl/core/kil_front.sv =====
// Lexer front: scans one character per beat, tracks the current word and
// classifies it into token pairs. Depends on kil_pkg.
`default_nettype none

module kil_front #(
    parameter int WORD_CHARS_KEPT = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    char_code,
    input  wire logic          end_of_input,
    output logic               push,
    output kil_pkg::tok_pair_t pair
);
    import kil_pkg::*;

    localparam int BUF_W = 8 * WORD_CHARS_KEPT;

    scan_mode_t        mode_reg, mode_next;
    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic [7:0]        count_reg, count_next;
    logic              digits_reg, digits_next;
    logic [62:0]       acc_reg, acc_next;
    logic              ovf_reg, ovf_next;

    logic              is_digit, is_alnum, is_space, is_hash, is_eol;
    logic [BUF_W-1:0]  base_buf, add_buf;
    logic [7:0]        base_count, add_count;
    logic              base_digits, add_digits;
    logic [62:0]       base_acc, add_acc;
    logic              base_ovf, add_ovf;
    logic [66:0]       acc_times10;
    logic              kw_hit;
    token_kind_t       kw_kind;
    word_tok_t         word_tok;

    assign is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
    assign is_alnum = is_digit || ((char_code >= 8'h61) && (char_code <= 8'h7A))
                    || ((char_code >= 8'h41) && (char_code <= 8'h5A));
    assign is_space = (char_code == CHAR_SPACE)
                    || ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
    assign is_hash  = (char_code == CHAR_HASH);
    assign is_eol   = (char_code == CHAR_LF) || (char_code == CHAR_CR);

    // A character that starts a word builds on a cleared word.
    always_comb
    begin
        if (mode_reg == MODE_WORD)
        begin
            base_buf    = buf_reg;
            base_count  = count_reg;
            base_digits = digits_reg;
            base_acc    = acc_reg;
            base_ovf    = ovf_reg;
        end
        else
        begin
            base_buf    = '0;
            base_count  = '0;
            base_digits = 1'b1;
            base_acc    = '0;
            base_ovf    = 1'b0;
        end
    end

    // value * 10 + digit in 67 bits; anything above bit 62 is an overflow.
    assign acc_times10 = ({4'b0, base_acc} << 3) + ({4'b0, base_acc} << 1)
                       + {63'b0, char_code[3:0]};

    always_comb
    begin
        add_buf = base_buf;
        for (int i = 0; i < WORD_CHARS_KEPT; i++)
        begin
            if (base_count == 8'(i))
            begin
                add_buf[8*i +: 8] = char_code;
            end
        end
        add_count  = (base_count == 8'hFF) ? base_count : base_count + 8'd1;
        add_digits = base_digits && is_digit;
        add_acc    = base_acc;
        add_ovf    = base_ovf;
        if (is_digit && base_digits && !base_ovf)
        begin
            if (acc_times10[66:63] != 4'b0)
            begin
                add_acc = INT_MAX;
                add_ovf = 1'b1;
            end
            else
            begin
                add_acc = acc_times10[62:0];
            end
        end
    end

    // Classification of the word held in the registers.
    always_comb
    begin
        kw_hit  = 1'b0;
        kw_kind = TOK_FUNC;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            if ((count_reg == KW_LEN[i]) && (64'(buf_reg) == KW_TEXT[i]))
            begin
                kw_hit  = 1'b1;
                kw_kind = KW_KIND[i];
            end
        end
        word_tok = '0;
        if (kw_hit)
        begin
            word_tok.kind = kw_kind;
        end
        else if (digits_reg)
        begin
            word_tok.kind  = TOK_INT;
            word_tok.value = {1'b0, acc_reg};
            word_tok.ovf   = ovf_reg;
        end
        else
        begin
            word_tok.kind  = TOK_IDENT;
            word_tok.value = 64'(buf_reg);
            word_tok.len   = count_reg;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        if (accept)
        begin
            if (end_of_input)
            begin
                mode_next = MODE_IDLE;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_COMMENT:
                    begin
                        if (is_eol)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_WORD, MODE_IDLE:
                    begin
                        if (is_alnum)
                        begin
                            mode_next = MODE_WORD;
                        end
                        else if (is_hash)
                        begin
                            mode_next = MODE_COMMENT;
                        end
                        else
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        push        = 1'b0;
        pair        = '0;
        pair.word   = word_tok;
        buf_next    = buf_reg;
        count_next  = count_reg;
        digits_next = digits_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        if (accept)
        begin
            if (end_of_input || ((mode_reg != MODE_COMMENT) && is_alnum))
            begin
                // Either the word is dropped after END, or the character joins it.
                buf_next    = end_of_input ? '0 : add_buf;
                count_next  = end_of_input ? '0 : add_count;
                digits_next = end_of_input ? 1'b1 : add_digits;
                acc_next    = end_of_input ? '0 : add_acc;
                ovf_next    = end_of_input ? 1'b0 : add_ovf;
            end
            else if (mode_reg == MODE_WORD)
            begin
                buf_next    = '0;
                count_next  = '0;
                digits_next = 1'b1;
                acc_next    = '0;
                ovf_next    = 1'b0;
            end

            if (end_of_input)
            begin
                push          = 1'b1;
                pair.has_word = (mode_reg == MODE_WORD);
                pair.has_sec  = 1'b1;
                pair.sec_kind = TOK_END;
            end
            else if ((mode_reg != MODE_COMMENT) && !is_alnum)
            begin
                pair.has_word = (mode_reg == MODE_WORD);
                pair.has_sec  = !is_space && !is_hash;
                pair.sec_kind = TOK_SYMBOL;
                pair.sec_sym  = char_code;
                push          = pair.has_word || pair.has_sec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            buf_reg    <= '0;
            count_reg  <= '0;
            digits_reg <= 1'b1;
            acc_reg    <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            buf_reg    <= buf_next;
            count_reg  <= count_next;
            digits_reg <= digits_next;
            acc_reg    <= acc_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/kil_queue.sv =====
// Short queue of token pairs between the lexer front and the back end.
// Depends on kil_pkg and the lexer assertion header.
`default_nettype none
`include "keyword_int_ident_lexer_assert.svh"

module kil_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire kil_pkg::tok_pair_t push_data,
    input  wire logic          pop,
    output kil_pkg::tok_pair_t pop_data,
    output logic               full,
    output logic               empty
);
    import kil_pkg::*;

    tok_pair_t              entries [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `KIL_ASSERT_NOW(a_no_push_when_full, clk, rst_n, push, !full)
    `KIL_ASSERT_NOW(a_no_pop_when_empty, clk, rst_n, pop, !empty)
    `KIL_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `KIL_ASSERT_NEXT(a_count_down, clk, rst_n, pop && !push, count_reg == $past(count_reg) - 1'b1)

endmodule

`default_nettype wire

// ===== rtl/core/kil_back.sv =====
// Lexer back end: takes token pairs from the queue and presents them one
// token per beat on the output channel. Depends on kil_pkg.
`default_nettype none

module kil_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire kil_pkg::tok_pair_t q_data,
    output logic               q_pop,
    output logic               token_valid,
    input  wire logic          token_stall,
    output logic [3:0]         token_kind,
    output logic [62:0]        int_value,
    output logic               int_overflow,
    output logic [63:0]        word_text,
    output logic [7:0]         word_length,
    output logic [7:0]         symbol_code,
    output logic               last_of_run
);
    import kil_pkg::*;

    tok_pair_t pair_reg;
    logic      rem_word_reg, rem_word_next;
    logic      rem_sec_reg, rem_sec_next;
    logic      taken, cur_last;

    assign token_valid = rem_word_reg || rem_sec_reg;
    assign taken       = token_valid && !token_stall;
    assign cur_last    = !(rem_word_reg && rem_sec_reg);
    assign q_pop       = !q_empty && (!token_valid || (taken && cur_last));

    always_comb
    begin
        rem_word_next = rem_word_reg;
        rem_sec_next  = rem_sec_reg;
        if (q_pop)
        begin
            rem_word_next = q_data.has_word;
            rem_sec_next  = q_data.has_sec;
        end
        else if (taken)
        begin
            if (rem_word_reg)
            begin
                rem_word_next = 1'b0;
            end
            else
            begin
                rem_sec_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        token_kind   = pair_reg.sec_kind;
        int_value    = '0;
        int_overflow = 1'b0;
        word_text    = '0;
        word_length  = '0;
        symbol_code  = pair_reg.sec_sym;
        last_of_run  = 1'b1;
        if (rem_word_reg)
        begin
            token_kind  = pair_reg.word.kind;
            symbol_code = '0;
            last_of_run = !rem_sec_reg;
            if (pair_reg.word.kind == TOK_INT)
            begin
                int_value    = pair_reg.word.value[62:0];
                int_overflow = pair_reg.word.ovf;
            end
            if (pair_reg.word.kind == TOK_IDENT)
            begin
                word_text   = pair_reg.word.value;
                word_length = pair_reg.word.len;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pair_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_word_reg <= 1'b0;
            rem_sec_reg  <= 1'b0;
        end
        else
        begin
            rem_word_reg <= rem_word_next;
            rem_sec_reg  <= rem_sec_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/keyword_int_ident_lexer.sv =====
// Top level of the keyword, integer and identifier lexer.
// Depends on kil_pkg, kil_front, kil_queue and kil_back.
//
// Use: the char channel (char_valid, char_stall, char_code, end_of_input)
// takes one character or an end mark per beat. The token channel
// (token_valid, token_stall and the token fields) gives one token per beat.
// A word token leaves when the character after the word arrives, or at the
// end mark; that character may add a second token (a SYMBOL, or END).
// last_of_run marks the final token caused by one input beat.
// Throughput: one character per cycle on the input while the pair queue
// has room, and one token per cycle on the output while token_stall is low.
// The front scans each character, decimal accumulate included, in logic
// ahead of its state registers; the back end drains the four-entry queue.
// A token passes through a queue entry, then the back end pair register.
// char_stall rises when the pair queue is full, which happens only while the
// receiver holds token_stall; tokens already shown stay put until taken.
// Reset clears the scan state to idle with an empty word and empties the
// queue; no token is pending afterwards.
`default_nettype none

module keyword_int_ident_lexer #(
    parameter int WORD_CHARS_KEPT = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        char_valid,
    output logic             char_stall,
    input  wire logic [7:0]  char_code,
    input  wire logic        end_of_input,
    output logic             token_valid,
    input  wire logic        token_stall,
    output logic [3:0]       token_kind,
    output logic [62:0]      int_value,
    output logic             int_overflow,
    output logic [63:0]      word_text,
    output logic [7:0]       word_length,
    output logic [7:0]       symbol_code,
    output logic             last_of_run
);
    import kil_pkg::*;

    logic      accept;
    logic      push, pop, q_full, q_empty;
    tok_pair_t push_pair, pop_pair;

    assign char_stall = q_full;
    assign accept     = char_valid && !char_stall;

    kil_front #(
        .WORD_CHARS_KEPT(WORD_CHARS_KEPT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_code   (char_code),
        .end_of_input(end_of_input),
        .push        (push),
        .pair        (push_pair)
    );

    kil_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_pair),
        .pop      (pop),
        .pop_data (pop_pair),
        .full     (q_full),
        .empty    (q_empty)
    );

    kil_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (pop_pair),
        .q_pop       (pop),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_kind  (token_kind),
        .int_value   (int_value),
        .int_overflow(int_overflow),
        .word_text   (word_text),
        .word_length (word_length),
        .symbol_code (symbol_code),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire
